/* hdl/tpp_pkg.sv */
package tpp_pkg;

  // packet geometry
  localparam int unsigned TsPacket    = 188;
  localparam int unsigned SingleRoom  = 177;
  localparam int unsigned FinalRoom   = 183;
  localparam int unsigned OutWordW    = 64;

  // header byte codes
  localparam logic [7:0] SyncByte     = 8'h47;
  localparam logic [7:0] PusiBit      = 8'h40;
  localparam logic [7:0] AfcAdapt     = 8'h30;
  localparam logic [7:0] AfcPayload   = 8'h10;
  localparam logic [7:0] RandAccess   = 8'h40;
  localparam logic [7:0] StuffByte    = 8'hFF;
  localparam logic [7:0] PesFlags     = 8'h80;
  localparam logic [7:0] PesHdrLen    = 8'h05;
  localparam logic [7:0] PtsPrefix    = 8'h21;

  // item codes
  localparam logic FuncStart = 1'b0;
  localparam logic FuncData  = 1'b1;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgPid     = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgVideoId = 1'b1;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic        func;
    logic [15:0] unit_length;
    logic [7:0]  unit_sid;
    logic [32:0] pts;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  byte_count;
    logic        end_of_packet;
    logic        end_of_unit;
  } out_item_t;

  typedef enum logic [1:0] {
    StIdle,
    StHdr,
    StData
  } state_e;

  typedef struct packed {
    logic load_unit;
    logic hdr_begin;
    logic hdr_step;
    logic data_now;
    logic data_held;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic left_zero;
    logic fill_zero;
    logic hdr_last;
  } stat_t;

endpackage

/* hdl/tpp_ctrl.sv */
module tpp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_func_i,
  input  tpp_pkg::stat_t stat_i,
  output logic           in_ready_o,
  output tpp_pkg::cmd_t  cmd_o
);
  import tpp_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = stat_i.slot_free;
        if (in_valid_i && stat_i.slot_free) begin
          if (in_func_i == FuncStart) begin
            cmd_o.load_unit = 1'b1;
          end else if (!stat_i.left_zero) begin
            if (stat_i.fill_zero) begin
              cmd_o.hdr_begin = 1'b1;
              state_d = StHdr;
            end else begin
              cmd_o.data_now = 1'b1;
            end
          end
        end
      end
      StHdr: begin
        if (stat_i.slot_free) begin
          cmd_o.hdr_step = 1'b1;
          if (stat_i.hdr_last) begin
            state_d = StData;
          end
        end
      end
      StData: begin
        if (stat_i.slot_free) begin
          cmd_o.data_held = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

/* hdl/tpp_dp.sv */
module tpp_dp #(
  parameter int unsigned WORD_BYTES = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tpp_pkg::in_item_t                in_item_i,
  input  logic                             cfg_write_i,
  input  logic [tpp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tpp_pkg::CfgDataW-1:0]     cfg_data_i,
  input  tpp_pkg::cmd_t                    cmd_i,
  output tpp_pkg::stat_t                   stat_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output tpp_pkg::out_item_t               out_item_o
);
  import tpp_pkg::*;

  localparam int unsigned AccW = 8 * WORD_BYTES;

  // configuration and unit state
  logic [12:0] pid_q;
  logic [7:0]  video_id_q;
  logic [3:0]  cc_q;
  logic [15:0] left_q;
  logic [7:0]  fill_q;
  logic        first_q;
  logic [7:0]  stream_q;
  logic [32:0] stamp_q;
  logic        stamp_on_q;
  logic [7:0]  byte_q;

  // header plan
  logic        plan_first_q, plan_adapt_q;
  logic [7:0]  plan_alen_q, plan_hlen_q, plan_pes_q, pos_q;

  // word accumulator and output register
  logic [AccW-1:0] acc_q;
  logic [3:0]      len_q;
  logic            out_valid_q;
  out_item_t       out_q;

  // plan for a new packet
  logic [16:0] need;
  logic        single, adapt_d;
  logic [7:0]  alen_d, adapt_len, pes_len, base_d;
  always_comb begin
    need      = {1'b0, left_q} + (stamp_on_q ? 17'd8 : 17'd0);
    single    = first_q && (need <= 17'(SingleRoom));
    adapt_d   = single || (!first_q && (left_q <= 16'(FinalRoom)));
    alen_d    = first_q ? 8'(SingleRoom - 32'(need))
                        : 8'(FinalRoom - 32'(left_q));
    adapt_len = adapt_d ? alen_d + 8'd1 : 8'd0;
    pes_len   = first_q ? (stamp_on_q ? 8'd14 : 8'd6) : 8'd0;
    base_d    = 8'd4 + adapt_len;
  end

  // header byte at the current position
  logic [7:0]  hdr_byte, q, r;
  logic [15:0] plen, v1, v2;
  always_comb begin
    q    = pos_q - 8'd4;
    r    = pos_q - plan_pes_q;
    plen = (stream_q == video_id_q) ? 16'd0 : left_q;
    v1   = {stamp_q[29:15], 1'b1};
    v2   = {stamp_q[14:0], 1'b1};
    hdr_byte = StuffByte;
    if (pos_q < 8'd4) begin
      case (pos_q[1:0])
        2'd0:    hdr_byte = SyncByte;
        2'd1:    hdr_byte = (plan_first_q ? PusiBit : 8'h00) | {3'b000, pid_q[12:8]};
        2'd2:    hdr_byte = pid_q[7:0];
        default: hdr_byte = (plan_adapt_q ? AfcAdapt : AfcPayload) | {4'h0, cc_q};
      endcase
    end else if (pos_q < plan_pes_q) begin
      if (q == 8'd0) begin
        hdr_byte = plan_alen_q;
      end else if (q == 8'd1) begin
        hdr_byte = plan_first_q ? RandAccess : 8'h00;
      end
    end else begin
      case (r[3:0])
        4'd0, 4'd1: hdr_byte = 8'h00;
        4'd2:       hdr_byte = 8'h01;
        4'd3:       hdr_byte = stream_q;
        4'd4:       hdr_byte = plen[15:8];
        4'd5:       hdr_byte = plen[7:0];
        4'd6, 4'd7: hdr_byte = PesFlags;
        4'd8:       hdr_byte = PesHdrLen;
        4'd9:       hdr_byte = PtsPrefix | {4'h0, stamp_q[32:30], 1'b0};
        4'd10:      hdr_byte = v1[15:8];
        4'd11:      hdr_byte = v1[7:0];
        4'd12:      hdr_byte = v2[15:8];
        4'd13:      hdr_byte = v2[7:0];
        default:    hdr_byte = 8'h00;
      endcase
    end
  end

  // byte push into the word accumulator
  logic            push, is_data, eop, eou, flush;
  logic [7:0]      push_byte, fill_next;
  logic [3:0]      len_next;
  logic [AccW+7:0] shifted;
  logic [AccW-1:0] acc_next;
  always_comb begin
    push      = cmd_i.hdr_step | cmd_i.data_now | cmd_i.data_held;
    is_data   = !cmd_i.hdr_step;
    push_byte = cmd_i.hdr_step ? hdr_byte : (cmd_i.data_now ? in_item_i.data_byte : byte_q);
    shifted   = {acc_q, push_byte};
    acc_next  = shifted[AccW-1:0];
    len_next  = len_q + 4'd1;
    fill_next = fill_q + 8'd1;
    eop       = (fill_next == 8'(TsPacket));
    eou       = is_data && (left_q == 16'd1);
    flush     = eop || is_data || (len_next == 4'(WORD_BYTES));
  end

  // status toward the controller
  always_comb begin
    stat_o.slot_free = !out_valid_q || out_ready_i;
    stat_o.left_zero = (left_q == 16'd0);
    stat_o.fill_zero = (fill_q == 8'd0);
    stat_o.hdr_last  = (pos_q == plan_hlen_q - 8'd1);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_q       <= '0;
      video_id_q  <= 8'hE0;
      cc_q        <= '0;
      left_q      <= '0;
      fill_q      <= '0;
      first_q     <= 1'b1;
      stream_q    <= '0;
      stamp_q     <= '0;
      stamp_on_q  <= 1'b0;
      acc_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        case (cfg_index_i)
          CfgPid:     pid_q <= cfg_data_i[12:0];
          CfgVideoId: video_id_q <= cfg_data_i[7:0];
          default:    ;
        endcase
      end
      if (cmd_i.load_unit) begin
        left_q     <= in_item_i.unit_length;
        stream_q   <= in_item_i.unit_sid;
        stamp_q    <= in_item_i.pts;
        stamp_on_q <= (in_item_i.pts != '0);
        first_q    <= 1'b1;
        fill_q     <= '0;
      end
      if (cmd_i.hdr_begin) begin
        first_q <= 1'b0;
      end
      if (cmd_i.hdr_step && pos_q == 8'd3) begin
        cc_q <= cc_q + 4'd1;
      end
      if (push) begin
        fill_q <= eop ? 8'd0 : fill_next;
        if (is_data) begin
          left_q <= left_q - 16'd1;
        end
        if (flush) begin
          acc_q <= '0;
          len_q <= '0;
        end else begin
          acc_q <= acc_next;
          len_q <= len_next;
        end
      end
      if (push && flush) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // header plan, held byte and output word registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_begin) begin
      byte_q       <= in_item_i.data_byte;
      plan_first_q <= first_q;
      plan_adapt_q <= adapt_d;
      plan_alen_q  <= alen_d;
      plan_pes_q   <= base_d;
      plan_hlen_q  <= base_d + pes_len;
      pos_q        <= '0;
    end else if (cmd_i.hdr_step) begin
      pos_q <= pos_q + 8'd1;
    end
    if (push && flush) begin
      out_q.out_word      <= OutWordW'(acc_next);
      out_q.byte_count    <= len_next;
      out_q.end_of_packet <= eop;
      out_q.end_of_unit   <= eou;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* hdl/ts_pes_packetizer_unit.sv */
// Transport stream packetizer: cuts access units into 188-byte packets.
// Input channel (in_valid_i/in_ready_o, in_item_i): a start beat carries the
// unit length, stream id and PTS; each following beat carries one payload
// byte. Output channel (out_valid_o/out_ready_i, out_item_o): words of up to
// WORD_BYTES stream bytes, right-justified, with end of packet / end of unit.
// Configuration channel (cfg_valid_i/cfg_ready_o): pid at index 0, video
// stream id at index 1; write only while idle.
// A start beat or a mid-packet payload byte is taken whenever the output slot is free.
// A byte that opens a packet is held while the header (4 to 187 bytes) is
// built one byte per cycle when the output slot is free, and is then pushed.
// Latency: the word holding a payload byte is valid the cycle after that
// byte leaves the byte sequencer.
// Reset clears the continuity counter and unit state; pid resets to 0 and
// the video stream id to 0xE0. A stalled receiver holds the output register
// and stops the sequencer, which in turn drops in_ready_o.
module ts_pes_packetizer_unit #(
  parameter int unsigned WORD_BYTES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tpp_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tpp_pkg::out_item_t           out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tpp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tpp_pkg::CfgDataW-1:0] cfg_data_i
);
  import tpp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  // sequencer
  tpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_item_i.func),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // byte builder and output register
  tpp_dp #(
    .WORD_BYTES (WORD_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_write_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
